/* hdl/asa_pkg.sv */
// shared types and constants for the atlas skyline allocator
// request and result beat structs, cell command struct and cell op codes
// no dependencies
package asa_pkg;

	localparam int DIM_W = 10;
	localparam int POS_W = 9;
	// wide enough for any column index, span end or height up to 4096
	localparam int CMD_W = 13;
	localparam int OP_W  = 3;

	localparam logic [OP_W-1:0] OP_HOLD  = 3'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd2;
	localparam logic [OP_W-1:0] OP_STEP  = 3'd3;
	localparam logic [OP_W-1:0] OP_SCAN  = 3'd4;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd5;

	typedef struct packed {
		logic             mode;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
	} req_t;

	typedef struct packed {
		logic             placed;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} res_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CMD_W-1:0] span_lo;
		logic [CMD_W-1:0] span_hi;
		logic [CMD_W-1:0] fill;
	} cell_cmd_t;

endpackage

/* hdl/asa_cell.sv */
// one column cell of the allocator chain: column height, sliding window tap
// and running window maximum; depends on asa_pkg
module asa_cell
	import asa_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int HGT_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic [HGT_W-1:0] win_in,
	input  logic [HGT_W-1:0] max_in,
	output logic [HGT_W-1:0] win_out,
	output logic [HGT_W-1:0] max_out
);

	localparam logic [CMD_W-1:0] MY_IDX = CMD_W'(IDX);

	logic [HGT_W-1:0] col_q;
	logic [HGT_W-1:0] win_q;
	logic [HGT_W-1:0] max_q;
	logic             in_span;

	assign in_span = (cmd.span_lo <= MY_IDX) && (MY_IDX < cmd.span_hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			col_q <= '0;
		end else if (cmd.op == OP_WRITE && in_span) begin
			col_q <= cmd.fill[HGT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				win_q <= col_q;
				max_q <= col_q;
			end
			OP_STEP: begin
				win_q <= win_in;
				if (win_in > max_q) begin
					max_q <= win_in;
				end
			end
			OP_SCAN: begin
				max_q <= max_in;
			end
			default: begin
			end
		endcase
	end

	assign win_out = win_q;
	assign max_out = max_q;

endmodule

/* hdl/atlas_skyline_allocator.sv */
// atlas skyline allocator: a chain of ATLAS_WIDTH column cells plus the sequencer
// allocate: from the accepted beat to the result the sequencer runs load,
// (w-1) window shift steps, (ATLAS_WIDTH-w+1) scan steps, write and strobe
// no fitting start skips the write; zero or oversized requests answer in the cycle after
// the beat, clear after the clear state; one item in flight at a time
// reset (arst_n low) zeroes every column height and returns the sequencer to idle
module atlas_skyline_allocator
	import asa_pkg::*;
#(
	parameter int ATLAS_WIDTH  = 512,
	parameter int ATLAS_HEIGHT = 512
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t res
);

	localparam int XW = $clog2(ATLAS_WIDTH);
	localparam int HW = $clog2(ATLAS_HEIGHT + 1);
	localparam logic [CMD_W-1:0] W_LIM = CMD_W'(ATLAS_WIDTH);
	localparam logic [CMD_W-1:0] H_LIM = CMD_W'(ATLAS_HEIGHT);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_WIN   = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_WRITE = 3'd5;

	logic [2:0]       state_q;
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [DIM_W-1:0] cnt_q;     // window steps done so far
	logic [XW-1:0]    scan_q;    // start column whose max sits at the head
	logic             found_q;
	logic [HW-1:0]    best_q;    // lowest level seen so far
	logic [XW-1:0]    bestx_q;   // leftmost start with that level
	logic             done_q;
	res_t             res_q;

	cell_cmd_t        cmd;
	logic [HW-1:0]    win_w [ATLAS_WIDTH+1];
	logic [HW-1:0]    max_w [ATLAS_WIDTH+1];

	logic             accept;
	logic             bad_req;
	logic [HW-1:0]    head;
	logic             fit;
	logic             take;
	logic             last_start;
	logic [CMD_W-1:0] ext_x;
	logic [CMD_W-1:0] ext_y;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign res    = res_q;

	// zero sized, too wide or too tall requests fail without touching the columns
	assign bad_req = (req.rect_width == '0) || (req.rect_height == '0)
		|| (CMD_W'(req.rect_width) > W_LIM) || (CMD_W'(req.rect_height) > H_LIM);

	// scan head: window max of start column scan_q
	assign head       = max_w[0];
	assign fit        = (CMD_W'(head) + CMD_W'(h_q)) <= H_LIM;
	assign take       = fit && (!found_q || head < best_q);
	assign last_start = (CMD_W'(scan_q) + CMD_W'(w_q)) == W_LIM;

	assign ext_x = CMD_W'(bestx_q);
	assign ext_y = CMD_W'(best_q);

	// command broadcast to every cell
	always_comb begin
		cmd.op      = OP_HOLD;
		cmd.span_lo = ext_x;
		cmd.span_hi = ext_x + CMD_W'(w_q);
		cmd.fill    = ext_y + CMD_W'(h_q);
		unique case (state_q)
			ST_CLEAR: cmd.op = OP_CLEAR;
			ST_LOAD:  cmd.op = OP_LOAD;
			ST_WIN:   cmd.op = OP_STEP;
			ST_SCAN:  cmd.op = OP_SCAN;
			ST_WRITE: cmd.op = OP_WRITE;
			default:  cmd.op = OP_HOLD;
		endcase
	end

	// beyond the last column the chain reads zero; those starts are never scanned
	assign win_w[ATLAS_WIDTH] = '0;
	assign max_w[ATLAS_WIDTH] = '0;

	for (genvar i = 0; i < ATLAS_WIDTH; i++) begin : g_cell
		asa_cell #(
			.IDX   (i),
			.HGT_W (HW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.win_in  (win_w[i+1]),
			.max_in  (max_w[i+1]),
			.win_out (win_w[i]),
			.max_out (max_w[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						w_q     <= req.rect_width;
						h_q     <= req.rect_height;
						found_q <= 1'b0;
						if (req.mode) begin
							state_q <= ST_CLEAR;
						end else if (bad_req) begin
							// failed allocation, answer at once
							done_q <= 1'b1;
							res_q  <= '0;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_CLEAR: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					res_q   <= '0;
				end
				ST_LOAD: begin
					cnt_q  <= DIM_W'(1);
					scan_q <= '0;
					if (w_q == DIM_W'(1)) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (cnt_q == w_q - DIM_W'(1)) begin
						state_q <= ST_SCAN;
					end else begin
						cnt_q <= cnt_q + DIM_W'(1);
					end
				end
				ST_SCAN: begin
					if (take) begin
						found_q <= 1'b1;
						best_q  <= head;
						bestx_q <= scan_q;
					end
					if (last_start) begin
						if (found_q || take) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
							res_q   <= '0;
						end
					end else begin
						scan_q <= scan_q + XW'(1);
					end
				end
				ST_WRITE: begin
					state_q      <= ST_IDLE;
					done_q       <= 1'b1;
					res_q.placed <= 1'b1;
					res_q.pos_x  <= ext_x[POS_W-1:0];
					res_q.pos_y  <= ext_y[POS_W-1:0];
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a placed result only follows a column write
	a_placed_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.placed) |-> $past(state_q) == ST_WRITE)
		else $error("placed result without column write");

	// column write only with a winning start
	a_write_needs_win: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> found_q)
		else $error("column write without a fitting start");

	// the scan never walks past the last start column
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CMD_W'(scan_q) + CMD_W'(w_q)) <= W_LIM)
		else $error("scan start past the last column");

	// the kept best always fits under the atlas top
	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && (state_q == ST_SCAN || state_q == ST_WRITE))
		|-> (CMD_W'(best_q) + CMD_W'(h_q)) <= H_LIM)
		else $error("best placement passes the atlas top");

	// an accepted allocate or clear keeps the block busy until its result
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode || !bad_req)) |=> busy)
		else $error("block idle right after an accepted beat");

endmodule
